@@ hw/rtl/sit_pkg.sv @@
// ============================================================================
// sit_pkg : shared types and constants of the segment intersection test
// Coordinate and arithmetic widths, orientation codes and the stage-enable
// bundle passed from the pipeline control to the orientation units.
// ============================================================================
package sit_pkg;

    // Coordinate width of every input field (two's complement)
    localparam int CoordBits = 16;
    // Difference of two coordinates
    localparam int DiffBits  = CoordBits + 1;
    // Signed product of two differences
    localparam int ProdBits  = 2 * DiffBits;
    // Square of a difference, at most 2**(2*CoordBits)
    localparam int SqBits    = 2 * CoordBits + 1;
    // Sum of two squares
    localparam int SumBits   = SqBits + 1;

    typedef logic signed [CoordBits-1:0] t_coord;
    typedef logic signed [DiffBits-1:0]  t_diff;
    typedef logic signed [ProdBits-1:0]  t_prod;
    typedef logic        [SqBits-1:0]    t_sq;
    typedef logic        [SumBits-1:0]   t_sum;
    typedef logic signed [1:0]           t_orient;

    // Orientation codes, -1 coded as all ones
    localparam t_orient OrientNeg  = 2'sb11;
    localparam t_orient OrientZero = 2'sb00;
    localparam t_orient OrientPos  = 2'sb01;

    // Load enables of the four stages inside an orientation unit
    typedef struct packed {
        logic diff;
        logic prod;
        logic cmp;
        logic res;
    } t_stage_en;

endpackage

@@ hw/rtl/sit_orient.sv @@
// ============================================================================
// sit_orient : pipelined orientation of a point against a directed segment
// Four register stages: differences, cross products and squares, cross
// compare and squared-length sums, final orientation code.
// ============================================================================
module sit_orient import sit_pkg::*; (
    input  logic      i_clk,
    input  t_stage_en i_en,
    input  t_coord    i_p0_x,
    input  t_coord    i_p0_y,
    input  t_coord    i_p1_x,
    input  t_coord    i_p1_y,
    input  t_coord    i_p2_x,
    input  t_coord    i_p2_y,
    output t_orient   o_orient
);

    t_diff   r_dx1, r_dy1, r_dx2, r_dy2;
    t_prod   r_left, r_right;
    t_sq     r_sq_dx1, r_sq_dy1, r_sq_dx2, r_sq_dy2;
    logic    r_behind_p, r_behind_c;
    logic    r_gt, r_lt;
    t_sum    r_len1, r_len2;
    t_orient r_orient;

    t_prod   w_sq_dx1, w_sq_dy1, w_sq_dx2, w_sq_dy2;
    logic    w_behind;

    // Take differences from the base point
    always_ff @(posedge i_clk) begin
        if (i_en.diff) begin
            r_dx1 <= DiffBits'(i_p1_x) - DiffBits'(i_p0_x);
            r_dy1 <= DiffBits'(i_p1_y) - DiffBits'(i_p0_y);
            r_dx2 <= DiffBits'(i_p2_x) - DiffBits'(i_p0_x);
            r_dy2 <= DiffBits'(i_p2_y) - DiffBits'(i_p0_y);
        end
    end

    // Squares are never negative, so the low bits hold the magnitude
    assign w_sq_dx1 = r_dx1 * r_dx1;
    assign w_sq_dy1 = r_dy1 * r_dy1;
    assign w_sq_dx2 = r_dx2 * r_dx2;
    assign w_sq_dy2 = r_dy2 * r_dy2;

    // Point lies behind the base when any axis points the opposite way
    assign w_behind =
        (r_dx1[DiffBits-1] && !r_dx2[DiffBits-1] && (r_dx2 != '0)) ||
        (r_dx2[DiffBits-1] && !r_dx1[DiffBits-1] && (r_dx1 != '0)) ||
        (r_dy1[DiffBits-1] && !r_dy2[DiffBits-1] && (r_dy2 != '0)) ||
        (r_dy2[DiffBits-1] && !r_dy1[DiffBits-1] && (r_dy1 != '0));

    // Form cross-product terms and squares
    always_ff @(posedge i_clk) begin
        if (i_en.prod) begin
            r_left     <= r_dx1 * r_dy2;
            r_right    <= r_dy1 * r_dx2;
            r_sq_dx1   <= w_sq_dx1[SqBits-1:0];
            r_sq_dy1   <= w_sq_dy1[SqBits-1:0];
            r_sq_dx2   <= w_sq_dx2[SqBits-1:0];
            r_sq_dy2   <= w_sq_dy2[SqBits-1:0];
            r_behind_p <= w_behind;
        end
    end

    // Compare cross terms, add up squared lengths
    always_ff @(posedge i_clk) begin
        if (i_en.cmp) begin
            r_gt       <= r_left > r_right;
            r_lt       <= r_left < r_right;
            r_len1     <= SumBits'(r_sq_dx1) + SumBits'(r_sq_dy1);
            r_len2     <= SumBits'(r_sq_dx2) + SumBits'(r_sq_dy2);
            r_behind_c <= r_behind_p;
        end
    end

    // Decide: turn direction first, then the collinear reach test
    always_ff @(posedge i_clk) begin
        if (i_en.res) begin
            if (r_gt) begin
                r_orient <= OrientPos;
            end else if (r_lt || r_behind_c) begin
                r_orient <= OrientNeg;
            end else if (r_len1 >= r_len2) begin
                r_orient <= OrientZero;
            end else begin
                r_orient <= OrientPos;
            end
        end
    end

    assign o_orient = r_orient;

endmodule

@@ hw/rtl/segment_intersection_test_top.sv @@
// ============================================================================
// segment_intersection_test_top : two-segment intersection by orientation
// Four orientation units run in lockstep; the output stage combines their
// signs into the intersect flag and holds the result beat.
// ============================================================================
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_a_*, i_b_* coordinates
//  out     | output    | o_out_valid / i_out_ready  | o_intersects, o_orient_*
//
//  An accepted beat passes the difference, product, compare, orientation and
//  result registers to output valid; one beat enters per cycle unless the output
//  stalls. The 17x17 products and 34-bit compares, one per stage, set the depth.
//  Synchronous active-low reset clears the stage valid bits only.
//  Each stage has its own ready, so a stall holds all data and bubbles
//  collapse while the output waits.
//
module segment_intersection_test_top import sit_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_coord  i_a_start_x,
    input  t_coord  i_a_start_y,
    input  t_coord  i_a_end_x,
    input  t_coord  i_a_end_y,
    input  t_coord  i_b_start_x,
    input  t_coord  i_b_start_y,
    input  t_coord  i_b_end_x,
    input  t_coord  i_b_end_y,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output logic    o_intersects,
    output t_orient o_orient_a_bstart,
    output t_orient o_orient_a_bend,
    output t_orient o_orient_b_astart,
    output t_orient o_orient_b_aend
);

    localparam int Stages = 5;

    logic [Stages-1:0] r_vld;
    logic [Stages-1:0] n_vld;
    logic [Stages-1:0] w_rdy;
    t_stage_en         w_en;

    t_orient w_o1, w_o2, w_o3, w_o4;
    logic    w_hit;

    logic    r_hit;
    t_orient r_o1, r_o2, r_o3, r_o4;

    // Ready of each stage: empty, or its content moves on this cycle
    always_comb begin
        w_rdy[Stages-1] = !r_vld[Stages-1] || i_out_ready;
        for (int k = Stages - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign w_en.diff = w_rdy[0];
    assign w_en.prod = w_rdy[1];
    assign w_en.cmp  = w_rdy[2];
    assign w_en.res  = w_rdy[3];

    // Advance valid bits along with the data
    always_comb begin
        n_vld = r_vld;
        if (w_rdy[0]) begin
            n_vld[0] = i_in_valid;
        end
        for (int k = 1; k < Stages; k++) begin
            if (w_rdy[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Orientations of B's endpoints against A, and of A's against B
    sit_orient u_orient_a_bstart (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_p0_x   (i_a_start_x),
        .i_p0_y   (i_a_start_y),
        .i_p1_x   (i_a_end_x),
        .i_p1_y   (i_a_end_y),
        .i_p2_x   (i_b_start_x),
        .i_p2_y   (i_b_start_y),
        .o_orient (w_o1)
    );

    sit_orient u_orient_a_bend (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_p0_x   (i_a_start_x),
        .i_p0_y   (i_a_start_y),
        .i_p1_x   (i_a_end_x),
        .i_p1_y   (i_a_end_y),
        .i_p2_x   (i_b_end_x),
        .i_p2_y   (i_b_end_y),
        .o_orient (w_o2)
    );

    sit_orient u_orient_b_astart (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_p0_x   (i_b_start_x),
        .i_p0_y   (i_b_start_y),
        .i_p1_x   (i_b_end_x),
        .i_p1_y   (i_b_end_y),
        .i_p2_x   (i_a_start_x),
        .i_p2_y   (i_a_start_y),
        .o_orient (w_o3)
    );

    sit_orient u_orient_b_aend (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_p0_x   (i_b_start_x),
        .i_p0_y   (i_b_start_y),
        .i_p1_x   (i_b_end_x),
        .i_p1_y   (i_b_end_y),
        .i_p2_x   (i_a_end_x),
        .i_p2_y   (i_a_end_y),
        .o_orient (w_o4)
    );

    // Sign product is positive only when both codes match and are nonzero
    assign w_hit = !((w_o1 == w_o2) && (w_o1 != OrientZero)) &&
                   !((w_o3 == w_o4) && (w_o3 != OrientZero));

    // Hold the result beat until the consumer takes it
    always_ff @(posedge i_clk) begin
        if (w_rdy[Stages-1]) begin
            r_hit <= w_hit;
            r_o1  <= w_o1;
            r_o2  <= w_o2;
            r_o3  <= w_o3;
            r_o4  <= w_o4;
        end
    end

    assign o_in_ready        = w_rdy[0];
    assign o_out_valid       = r_vld[Stages-1];
    assign o_intersects      = r_hit;
    assign o_orient_a_bstart = r_o1;
    assign o_orient_a_bend   = r_o2;
    assign o_orient_b_astart = r_o3;
    assign o_orient_b_aend   = r_o4;

    // Input backpressure only when every stage holds a beat
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_vld == '1))
        else $error("input stalled while pipeline has a free stage");

    // An accepted beat lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted beat not captured");

    // No unused orientation code reaches the output
    a_orient_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_orient_a_bstart != 2'sb10) && (o_orient_a_bend != 2'sb10) &&
                        (o_orient_b_astart != 2'sb10) && (o_orient_b_aend != 2'sb10))
        else $error("invalid orientation code on output");

    // A hit never comes with both B endpoints strictly on one side of A
    a_hit_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_intersects) |->
            !((o_orient_a_bstart == o_orient_a_bend) && (o_orient_a_bstart != OrientZero)))
        else $error("intersect flag disagrees with orientations");

endmodule
